>>> rtl/b64c_pkg.sv
package b64c_pkg;

   // most beats one item can cause: four characters on the last byte
   localparam int unsigned MaxBeats = 4;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // one result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic       end_of_stream;
   } beat_type;

   // all result beats of one item, slot 0 goes out first
   typedef struct packed {
      beat_type [MaxBeats-1:0] beat;
      logic [$clog2(MaxBeats+1)-1:0] count;
   } batch_type;

   // decoded character: ok low means it stops decoding
   typedef struct packed {
      logic       ok;
      logic [5:0] val;
   } sextet_type;

   // six-bit value to alphabet character
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         return w + 8'h41;
      end else if (v < 6'd52) begin
         return w + 8'h47;
      end else if (v < 6'd62) begin
         return w - 8'd4;
      end else if (v == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

   // alphabet character to six-bit value
   function automatic sextet_type char_sextet(input logic [7:0] c);
      sextet_type s;
      s = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.ok  = 1'b1;
         s.val = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.ok  = 1'b1;
         s.val = 6'(c - 8'h47);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.ok  = 1'b1;
         s.val = 6'(c + 8'd4);
      end else if (c == 8'h2B) begin
         s.ok  = 1'b1;
         s.val = 6'd62;
      end else if (c == 8'h2F) begin
         s.ok  = 1'b1;
         s.val = 6'd63;
      end
      return s;
   endfunction

endpackage

>>> rtl/b64c_core.sv
module b64c_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_wdata,
   input  logic                fire,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output b64c_pkg::batch_type batch
);

   logic        mode_ff;
   logic [11:0] acc_ff, acc_in;
   logic [2:0]  pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        stop_ff, stop_in;

   // encode path
   logic [11:0] enc_acc;
   logic [3:0]  enc_p;
   logic        enc_two;
   logic [5:0]  enc_c0, enc_c1, enc_tail;
   logic [2:0]  enc_rest;
   logic        enc_tail_on;
   logic [1:0]  enc_n, enc_cnt, enc_pads;
   logic [2:0]  enc_total;
   logic [5:0]  enc_sx [3];

   // decode path
   b64c_pkg::sextet_type dec_sx;
   logic [11:0] dec_acc;
   logic [3:0]  dec_p;
   logic        dec_emit, dec_live;
   logic [7:0]  dec_byte;
   logic [2:0]  dec_rest;

   // encode: append the byte, take one or two characters, tail and padding on last
   always_comb begin
      enc_acc     = {acc_ff[3:0], in_byte};
      enc_p       = {1'b0, pend_ff} + 4'd8;
      enc_two     = enc_p >= 4'd12;
      enc_c0      = 6'(enc_acc >> (enc_p - 4'd6));
      enc_c1      = 6'(enc_acc >> (enc_p - 4'd12));
      enc_rest    = enc_two ? 3'(enc_p - 4'd12) : 3'(enc_p - 4'd6);
      enc_tail_on = in_last && enc_rest != 3'd0 && enc_rest < 3'd6;
      enc_tail    = 6'(enc_acc << (3'd6 - enc_rest));
      enc_n       = 2'd1 + {1'b0, enc_two} + {1'b0, enc_tail_on};
      enc_cnt     = cnt_ff + enc_n;
      enc_pads    = 2'd0 - enc_cnt;
      enc_total   = {1'b0, enc_n} + {1'b0, enc_pads};
      if (enc_total > 3'd4) begin
         enc_total = 3'd4;
      end
      enc_sx[0] = enc_c0;
      enc_sx[1] = enc_two ? enc_c1 : enc_tail;
      enc_sx[2] = enc_tail;
   end

   // decode: append the sextet, a byte out once eight bits are pending
   always_comb begin
      dec_sx   = b64c_pkg::char_sextet(in_byte);
      dec_acc  = {acc_ff[5:0], dec_sx.val};
      dec_p    = {1'b0, pend_ff} + 4'd6;
      dec_emit = dec_p >= 4'd8;
      dec_byte = 8'(dec_acc >> (dec_p - 4'd8));
      dec_rest = dec_emit ? 3'(dec_p - 4'd8) : 3'(dec_p);
      dec_live = !stop_ff && dec_sx.ok;
   end

   // result beats and next stream state
   always_comb begin
      batch   = '0;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      stop_in = stop_ff;
      if (mode_ff == b64c_pkg::MODE_ENCODE) begin
         acc_in  = enc_acc;
         pend_in = enc_rest;
         cnt_in  = enc_cnt;
         batch.count = in_last ? enc_total : {1'b0, enc_n};
         for (int k = 0; k < b64c_pkg::MaxBeats; k++) begin
            if (k < 3 && 2'(k) < enc_n) begin
               batch.beat[k].out_byte = b64c_pkg::sextet_char(enc_sx[k < 3 ? k : 0]);
            end else begin
               batch.beat[k].out_byte = b64c_pkg::PAD_CHAR;
            end
            batch.beat[k].has_data = 1'b1;
            batch.beat[k].end_of_stream = in_last && (3'(k) == enc_total - 3'd1);
         end
      end else begin
         if (!stop_ff && !dec_sx.ok) begin
            stop_in = 1'b1;
         end
         if (dec_live) begin
            acc_in  = dec_acc;
            pend_in = dec_rest;
         end
         if (dec_live && dec_emit) begin
            batch.count = 3'd1;
            batch.beat[0].out_byte = dec_byte;
            batch.beat[0].has_data = 1'b1;
         end
         if (in_last) begin
            // a bare end marker when the last character gives no byte
            batch.count = 3'd1;
            batch.beat[0].end_of_stream = 1'b1;
         end
      end
      if (in_last) begin
         acc_in  = '0;
         pend_in = '0;
         cnt_in  = '0;
         stop_in = 1'b0;
      end
   end

   // mode and stream state, a mode write starts a fresh stream
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= b64c_pkg::MODE_ENCODE;
         acc_ff  <= '0;
         pend_ff <= '0;
         cnt_ff  <= '0;
         stop_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
         acc_ff  <= '0;
         pend_ff <= '0;
         cnt_ff  <= '0;
         stop_ff <= 1'b0;
      end else if (fire) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         stop_ff <= stop_in;
      end
   end

endmodule

>>> rtl/b64c_emit.sv
module b64c_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  b64c_pkg::batch_type batch,
   output logic                load_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output b64c_pkg::beat_type  rsp_beat
);

   b64c_pkg::beat_type [b64c_pkg::MaxBeats-1:0] beat_ff;
   logic [$clog2(b64c_pkg::MaxBeats+1)-1:0] rem_ff;
   logic [$clog2(b64c_pkg::MaxBeats)-1:0]   idx_ff;

   // a new batch may load once the last held beat leaves
   always_comb begin
      rsp_valid = rem_ff != '0;
      load_ok   = rem_ff == '0 || (rem_ff == 3'd1 && !rsp_stall);
      rsp_beat  = beat_ff[idx_ff];
   end

   // held beats go out one per cycle while rsp_stall is low
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else if (fire) begin
         rem_ff <= batch.count;
         idx_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         rem_ff <= rem_ff - 3'd1;
         idx_ff <= idx_ff + 2'd1;
      end
   end

   // beat payload
   always_ff @(posedge clock) begin
      if (fire) begin
         beat_ff <= batch.beat;
      end
   end

endmodule

>>> rtl/base64_stream_codec.sv
// Streaming Base64 codec, standard alphabet with '=' padding.
// csr_we with csr_wdata selects the mode (0 encode, 1 decode) and starts a
// fresh stream; write it only while the block is idle.
// Request channel: req_in_byte is a data byte (encode) or a character
// (decode), req_last marks the final item of a stream. A beat is taken when
// req_valid is high and req_stall is low.
// Response channel: one character or byte per beat; rsp_has_data low marks a
// bare end marker, rsp_end_of_stream flags the last beat of the stream.
// An item enters an input register, is worked out once the output buffer can
// take its beats, and its beats then load into that output buffer. Encode
// gives one or two beats per byte (up to four on the last), decode zero or
// one; the output buffer sends one beat per cycle while rsp_stall is low, so
// sustained rate is set by the beat count of each item.
// A new item is worked out in the cycle the buffer's last beat leaves.
// While rsp_stall is high the current beat holds and, once the input
// register is full, req_stall rises. Reset empties both registers, selects
// encode mode and clears the stream state.
module base64_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_data,
   output logic       rsp_end_of_stream
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       load_ok, fire;
   b64c_pkg::batch_type batch;
   b64c_pkg::beat_type  rsp_beat;

   // the held item moves on once the output buffer can take its beats
   always_comb begin
      fire      = in_valid_ff && load_ok;
      req_stall = in_valid_ff && !fire;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last;
      end
   end

   b64c_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .batch     (batch)
   );

   b64c_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .batch     (batch),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   // response payload
   always_comb begin
      rsp_out_byte      = rsp_beat.out_byte;
      rsp_has_data      = rsp_beat.has_data;
      rsp_end_of_stream = rsp_beat.end_of_stream;
   end

endmodule
